// File: rtl/assert_macros.svh
// Concurrent assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gqa_pkg.sv
package gqa_pkg;

  localparam int CNT_W = 6;  // covers the longest loop (divider, up to 61 steps)

  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_RMUL   = 5'd2;
  localparam logic [4:0] OP_RSET   = 5'd3;
  localparam logic [4:0] OP_DMUL   = 5'd4;
  localparam logic [4:0] OP_DACC   = 5'd5;
  localparam logic [4:0] OP_SHI    = 5'd6;
  localparam logic [4:0] OP_SLO    = 5'd7;
  localparam logic [4:0] OP_SSUM   = 5'd8;
  localparam logic [4:0] OP_CSET   = 5'd9;
  localparam logic [4:0] OP_QMUL   = 5'd10;
  localparam logic [4:0] OP_QACC   = 5'd11;
  localparam logic [4:0] OP_SQINIT = 5'd12;
  localparam logic [4:0] OP_SQSTEP = 5'd13;
  localparam logic [4:0] OP_IDENT  = 5'd14;
  localparam logic [4:0] OP_DVINIT = 5'd15;
  localparam logic [4:0] OP_DVSTEP = 5'd16;
  localparam logic [4:0] OP_DVSET  = 5'd17;
  localparam logic [4:0] OP_YMUL   = 5'd18;
  localparam logic [4:0] OP_YACC   = 5'd19;
  localparam logic [4:0] OP_YPRE   = 5'd20;
  localparam logic [4:0] OP_CSTEP  = 5'd21;
  localparam logic [4:0] OP_OUT    = 5'd22;

  localparam logic [2:0] REG_BIAS_X   = 3'd0;
  localparam logic [2:0] REG_BIAS_Y   = 3'd1;
  localparam logic [2:0] REG_BIAS_Z   = 3'd2;
  localparam logic [2:0] REG_SCALE    = 3'd3;
  localparam logic [2:0] REG_DEADBAND = 3'd4;
  localparam logic [2:0] REG_STEP     = 3'd5;

  // 180 degrees in centidegree * 2^16 units
  localparam logic signed [31:0] ANG_HALF_TURN = 32'sd1179648000;

  typedef struct packed {
    logic [4:0]       op;
    logic [1:0]       comp;
    logic [1:0]       term;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic tiny;
  } stat_t;

  typedef struct packed {
    logic [1:0] qa;
    logic [1:0] gb;
    logic       neg;
  } dterm_t;

  // Quaternion product terms: component comp, term index term
  function automatic dterm_t dterm(input logic [1:0] comp, input logic [1:0] term);
    dterm_t d;
    case ({comp, term})
      4'h0: d = '{qa: 2'd1, gb: 2'd0, neg: 1'b1};
      4'h1: d = '{qa: 2'd2, gb: 2'd1, neg: 1'b1};
      4'h2: d = '{qa: 2'd3, gb: 2'd2, neg: 1'b1};
      4'h4: d = '{qa: 2'd0, gb: 2'd0, neg: 1'b0};
      4'h5: d = '{qa: 2'd2, gb: 2'd2, neg: 1'b0};
      4'h6: d = '{qa: 2'd3, gb: 2'd1, neg: 1'b1};
      4'h8: d = '{qa: 2'd0, gb: 2'd1, neg: 1'b0};
      4'h9: d = '{qa: 2'd1, gb: 2'd2, neg: 1'b1};
      4'hA: d = '{qa: 2'd3, gb: 2'd0, neg: 1'b0};
      4'hC: d = '{qa: 2'd0, gb: 2'd2, neg: 1'b0};
      4'hD: d = '{qa: 2'd1, gb: 2'd1, neg: 1'b0};
      4'hE: d = '{qa: 2'd2, gb: 2'd0, neg: 1'b1};
      default: d = '{qa: 2'd0, gb: 2'd0, neg: 1'b0};
    endcase
    return d;
  endfunction

  // atan(2^-i) in centidegree * 2^16 units
  function automatic logic signed [31:0] atan_at(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:  a = 32'sd294912000;
      5'd1:  a = 32'sd174096719;
      5'd2:  a = 32'sd91987925;
      5'd3:  a = 32'sd46694507;
      5'd4:  a = 32'sd23437865;
      5'd5:  a = 32'sd11730358;
      5'd6:  a = 32'sd5866610;
      5'd7:  a = 32'sd2933484;
      5'd8:  a = 32'sd1466764;
      5'd9:  a = 32'sd733385;
      5'd10: a = 32'sd366693;
      5'd11: a = 32'sd183346;
      5'd12: a = 32'sd91673;
      5'd13: a = 32'sd45837;
      5'd14: a = 32'sd22918;
      5'd15: a = 32'sd11459;
      5'd16: a = 32'sd5730;
      5'd17: a = 32'sd2865;
      5'd18: a = 32'sd1432;
      5'd19: a = 32'sd716;
      5'd20: a = 32'sd358;
      5'd21: a = 32'sd179;
      5'd22: a = 32'sd90;
      5'd23: a = 32'sd45;
      5'd24: a = 32'sd22;
      5'd25: a = 32'sd11;
      5'd26: a = 32'sd6;
      5'd27: a = 32'sd3;
      5'd28: a = 32'sd1;
      5'd29: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/gqa_ifs.sv
interface gqa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rate_x_raw;
  logic signed [15:0] rate_y_raw;
  logic signed [15:0] rate_z_raw;
  modport source (output valid, rate_x_raw, rate_y_raw, rate_z_raw, input ready);
  modport sink (input valid, rate_x_raw, rate_y_raw, rate_z_raw, output ready);
endinterface

interface gqa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [15:0] yaw_centideg;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, yaw_centideg, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, yaw_centideg, output ready);
endinterface

interface gqa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/gqa_ctrl.sv
`include "assert_macros.svh"

module gqa_ctrl #(
  parameter int QUAT_FRAC_BITS = 30,
  parameter int CORDIC_STEPS   = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  gqa_pkg::stat_t stat,
  output gqa_pkg::cmd_t  cmd
);

  localparam int CW = gqa_pkg::CNT_W;
  localparam logic [CW-1:0] DV_LAST = CW'(QUAT_FRAC_BITS + 30);
  localparam logic [CW-1:0] CS_LAST = CW'(CORDIC_STEPS - 1);
  localparam logic [CW-1:0] SQ_LAST = CW'(31);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RMUL   = 5'd1;
  localparam logic [4:0] S_RSET   = 5'd2;
  localparam logic [4:0] S_DMUL   = 5'd3;
  localparam logic [4:0] S_DACC   = 5'd4;
  localparam logic [4:0] S_SHI    = 5'd5;
  localparam logic [4:0] S_SLO    = 5'd6;
  localparam logic [4:0] S_SSUM   = 5'd7;
  localparam logic [4:0] S_CSET   = 5'd8;
  localparam logic [4:0] S_QMUL   = 5'd9;
  localparam logic [4:0] S_QACC   = 5'd10;
  localparam logic [4:0] S_SQINIT = 5'd11;
  localparam logic [4:0] S_SQSTEP = 5'd12;
  localparam logic [4:0] S_TINY   = 5'd13;
  localparam logic [4:0] S_DVINIT = 5'd14;
  localparam logic [4:0] S_DVSTEP = 5'd15;
  localparam logic [4:0] S_DVSET  = 5'd16;
  localparam logic [4:0] S_YMUL   = 5'd17;
  localparam logic [4:0] S_YACC   = 5'd18;
  localparam logic [4:0] S_YPRE   = 5'd19;
  localparam logic [4:0] S_CSTEP  = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;

  logic [4:0]    state_r, state_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic [1:0]    term_r, term_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [4:0]    op;

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    term_nxt  = term_r;
    cnt_nxt   = cnt_r;
    op        = gqa_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = gqa_pkg::OP_LOAD;
          comp_nxt  = 2'd0;
          term_nxt  = 2'd0;
          cnt_nxt   = '0;
          state_nxt = S_RMUL;
        end
      end
      S_RMUL: begin
        op        = gqa_pkg::OP_RMUL;
        state_nxt = S_RSET;
      end
      S_RSET: begin
        op = gqa_pkg::OP_RSET;
        if (comp_r == 2'd2) begin
          comp_nxt  = 2'd0;
          state_nxt = S_DMUL;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_RMUL;
        end
      end
      S_DMUL: begin
        op        = gqa_pkg::OP_DMUL;
        state_nxt = S_DACC;
      end
      S_DACC: begin
        op = gqa_pkg::OP_DACC;
        if (term_r == 2'd2) begin
          term_nxt  = 2'd0;
          state_nxt = S_SHI;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_DMUL;
        end
      end
      S_SHI: begin
        op        = gqa_pkg::OP_SHI;
        state_nxt = S_SLO;
      end
      S_SLO: begin
        op        = gqa_pkg::OP_SLO;
        state_nxt = S_SSUM;
      end
      S_SSUM: begin
        op        = gqa_pkg::OP_SSUM;
        state_nxt = S_CSET;
      end
      S_CSET: begin
        op        = gqa_pkg::OP_CSET;
        state_nxt = S_QMUL;
      end
      S_QMUL: begin
        op        = gqa_pkg::OP_QMUL;
        state_nxt = S_QACC;
      end
      S_QACC: begin
        op = gqa_pkg::OP_QACC;
        if (comp_r == 2'd3) begin
          comp_nxt  = 2'd0;
          state_nxt = S_SQINIT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_DMUL;
        end
      end
      S_SQINIT: begin
        op        = gqa_pkg::OP_SQINIT;
        cnt_nxt   = '0;
        state_nxt = S_SQSTEP;
      end
      S_SQSTEP: begin
        op = gqa_pkg::OP_SQSTEP;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_TINY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_TINY: begin
        // norm check picks reset-to-identity or the four divisions
        if (stat.tiny) begin
          op        = gqa_pkg::OP_IDENT;
          comp_nxt  = 2'd0;
          state_nxt = S_YMUL;
        end else begin
          op        = gqa_pkg::OP_DVINIT;
          cnt_nxt   = '0;
          state_nxt = S_DVSTEP;
        end
      end
      S_DVINIT: begin
        op        = gqa_pkg::OP_DVINIT;
        cnt_nxt   = '0;
        state_nxt = S_DVSTEP;
      end
      S_DVSTEP: begin
        op = gqa_pkg::OP_DVSTEP;
        if (cnt_r == DV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DVSET;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DVSET: begin
        op = gqa_pkg::OP_DVSET;
        if (comp_r == 2'd3) begin
          comp_nxt  = 2'd0;
          state_nxt = S_YMUL;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_DVINIT;
        end
      end
      S_YMUL: begin
        op        = gqa_pkg::OP_YMUL;
        state_nxt = S_YACC;
      end
      S_YACC: begin
        op = gqa_pkg::OP_YACC;
        if (comp_r == 2'd3) begin
          comp_nxt  = 2'd0;
          state_nxt = S_YPRE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_YMUL;
        end
      end
      S_YPRE: begin
        op        = gqa_pkg::OP_YPRE;
        cnt_nxt   = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        op = gqa_pkg::OP_CSTEP;
        if (cnt_r == CS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          op        = gqa_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (op == gqa_pkg::OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      comp_r      <= 2'd0;
      term_r      <= 2'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      comp_r      <= comp_nxt;
      term_r      <= term_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.op   = op;
  assign cmd.comp = comp_r;
  assign cmd.term = term_r;
  assign cmd.cnt  = cnt_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_SAME(a_out_slot_free, op == gqa_pkg::OP_OUT, !out_valid_r || out_ready, "result overwrites an untaken result")
  `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_RMUL && comp_r == 2'd0, "accepted item did not start the rate phase")
  `ASSERT_NEXT(a_tiny_skips_div, state_r == S_TINY && stat.tiny, state_r == S_YMUL && comp_r == 2'd0, "tiny norm did not skip the divider")
  `ASSERT_SAME(a_div_count, state_r == S_DVSTEP, cnt_r <= DV_LAST, "divider step count out of range")

endmodule

// File: rtl/gqa_datapath.sv
module gqa_datapath #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gqa_pkg::cmd_t      cmd,
  output gqa_pkg::stat_t     stat,
  input  logic signed [15:0] rate_x_raw,
  input  logic signed [15:0] rate_y_raw,
  input  logic signed [15:0] rate_z_raw,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic signed [15:0] yaw_centideg
);

  localparam int DVW = QUAT_FRAC_BITS + 31;   // divider dividend width
  localparam int YW  = 67 - QUAT_FRAC_BITS;   // CORDIC vector width
  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< QUAT_FRAC_BITS;
  localparam logic [45:0] TINY_LIM = 46'd1 << (QUAT_FRAC_BITS - 1);
  localparam logic signed [63:0] Y_ONE = 64'sd1 <<< (2 * QUAT_FRAC_BITS);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic signed [15:0] bias_r [3];
  logic [15:0]        scale_r;
  logic [23:0]        dband_r;
  logic [23:0]        step_r;
  logic signed [15:0] raw_r [3];
  logic signed [31:0] g_r [3];
  logic signed [31:0] att_r [4];
  logic signed [31:0] c_r [4];
  logic signed [63:0] p_r, acc_r, t_r;
  logic [63:0]        v_r, res_r, bit_r;
  logic [DVW-1:0]     dvd_r;
  logic [31:0]        rem_r;
  logic signed [YW-1:0] sn_r, cs_r;
  logic signed [31:0] ang_r;
  logic               yzero_r;
  logic signed [31:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [15:0] yaw_r;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic signed [16:0] rdiff;
  logic signed [63:0] sfull;
  logic signed [39:0] s40;
  gqa_pkg::dterm_t    dt;
  logic signed [31:0] cc;

  assign cc    = c_r[cmd.comp];
  assign dt    = gqa_pkg::dterm(cmd.comp, cmd.term);
  assign rdiff = {raw_r[cmd.comp[1:0]][15], raw_r[cmd.comp[1:0]]}
               - {bias_r[cmd.comp[1:0]][15], bias_r[cmd.comp[1:0]]};
  assign sfull = (acc_r + 64'sd8388608) >>> 24;
  assign s40   = sfull[39:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      gqa_pkg::OP_RMUL: begin
        ma = {{16{rdiff[16]}}, rdiff};
        mb = {17'd0, scale_r};
      end
      gqa_pkg::OP_DMUL: begin
        ma = {att_r[dt.qa][31], att_r[dt.qa]};
        mb = {g_r[dt.gb][31], g_r[dt.gb]};
      end
      gqa_pkg::OP_SHI: begin
        ma = {{13{s40[39]}}, s40[39:20]};
        mb = {9'd0, step_r};
      end
      gqa_pkg::OP_SLO: begin
        ma = {13'd0, s40[19:0]};
        mb = {9'd0, step_r};
      end
      gqa_pkg::OP_QMUL: begin
        ma = {cc[31], cc};
        mb = {cc[31], cc};
      end
      gqa_pkg::OP_YMUL: begin
        case (cmd.comp)
          2'd0: begin
            ma = {att_r[0][31], att_r[0]};
            mb = {att_r[3][31], att_r[3]};
          end
          2'd1: begin
            ma = {att_r[1][31], att_r[1]};
            mb = {att_r[2][31], att_r[2]};
          end
          2'd2: begin
            ma = {att_r[2][31], att_r[2]};
            mb = {att_r[2][31], att_r[2]};
          end
          default: begin
            ma = {att_r[3][31], att_r[3]};
            mb = {att_r[3][31], att_r[3]};
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mprod = ma * mb;

  // rate saturation and deadband
  logic signed [31:0] rsat;
  logic [32:0]        rmag;
  assign rsat = sat32(p_r);
  assign rmag = rsat[31] ? (33'd0 - {1'b1, rsat}) : {1'b0, rsat};

  // component update
  logic signed [63:0] dval, r25, csum;
  assign dval = dt.neg ? (64'sd0 - p_r) : p_r;
  assign r25  = (t_r + 64'sd16777216) >>> 25;
  assign csum = {{32{att_r[cmd.comp][31]}}, att_r[cmd.comp]} + r25;

  // square root step
  logic [63:0] rb;
  assign rb = res_r + bit_r;

  // norm and divider
  logic [31:0]    rr;
  logic [45:0]    rk;
  logic [31:0]    cabs;
  logic [32:0]    dtry;
  logic           dge;
  logic [DVW-1:0] q;
  logic           qbig_pos, qbig_neg;
  assign rr       = res_r[31:0];
  assign rk       = {14'd0, rr} * 46'd10000;
  assign stat.tiny = rk < TINY_LIM;
  assign cabs     = cc[31] ? (32'd0 - cc) : cc;
  assign dtry     = {rem_r, dvd_r[DVW-1]};
  assign dge      = dtry >= {1'b0, rr};
  assign q        = dvd_r;
  assign qbig_pos = q > DVW'(64'h7FFFFFFF);
  assign qbig_neg = q > DVW'(64'h80000000);

  // yaw operands
  logic signed [63:0] ysum, y2, ysh, ycs, ycsh;
  assign ysum = acc_r + p_r;
  assign y2   = ysum <<< 1;
  assign ysh  = y2 >>> QUAT_FRAC_BITS;
  assign ycs  = Y_ONE - y2;
  assign ycsh = ycs >>> QUAT_FRAC_BITS;

  // CORDIC step
  logic [4:0]           ci;
  logic signed [YW-1:0] shs, shc;
  logic signed [31:0]   atn;
  assign ci  = cmd.cnt[4:0];
  assign shs = sn_r >>> ci;
  assign shc = cs_r >>> ci;
  assign atn = gqa_pkg::atan_at(ci);

  // yaw rounding and clamp
  logic signed [31:0] yr;
  assign yr = (ang_r + 32'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r[0] <= '0;
      bias_r[1] <= '0;
      bias_r[2] <= '0;
      scale_r   <= 16'd17852;
      dband_r   <= 24'd2516582;
      step_r    <= 24'd83886;
    end else if (cfg_we) begin
      case (cfg_index)
        gqa_pkg::REG_BIAS_X:   bias_r[0] <= cfg_data[15:0];
        gqa_pkg::REG_BIAS_Y:   bias_r[1] <= cfg_data[15:0];
        gqa_pkg::REG_BIAS_Z:   bias_r[2] <= cfg_data[15:0];
        gqa_pkg::REG_SCALE:    scale_r   <= cfg_data[15:0];
        gqa_pkg::REG_DEADBAND: dband_r   <= cfg_data;
        gqa_pkg::REG_STEP:     step_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_r[0] <= Q_ONE;
      att_r[1] <= '0;
      att_r[2] <= '0;
      att_r[3] <= '0;
    end else begin
      case (cmd.op)
        gqa_pkg::OP_IDENT: begin
          att_r[0] <= Q_ONE;
          att_r[1] <= '0;
          att_r[2] <= '0;
          att_r[3] <= '0;
        end
        gqa_pkg::OP_DVSET: begin
          if (cc[31]) begin
            att_r[cmd.comp] <= qbig_neg ? 32'sh80000000 : (32'd0 - q[31:0]);
          end else begin
            att_r[cmd.comp] <= qbig_pos ? 32'sh7FFFFFFF : q[31:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      gqa_pkg::OP_LOAD: begin
        raw_r[0] <= rate_x_raw;
        raw_r[1] <= rate_y_raw;
        raw_r[2] <= rate_z_raw;
      end
      gqa_pkg::OP_RMUL, gqa_pkg::OP_DMUL, gqa_pkg::OP_SHI, gqa_pkg::OP_QMUL,
      gqa_pkg::OP_YMUL: begin
        p_r <= mprod[63:0];
      end
      gqa_pkg::OP_RSET: begin
        g_r[cmd.comp[1:0]] <= (rmag < {9'd0, dband_r}) ? 32'sd0 : rsat;
      end
      gqa_pkg::OP_DACC: begin
        acc_r <= (cmd.term == 2'd0) ? dval : (acc_r + dval);
      end
      gqa_pkg::OP_SLO: begin
        t_r <= p_r <<< 20;
        p_r <= mprod[63:0];
      end
      gqa_pkg::OP_SSUM: begin
        t_r <= t_r + p_r;
      end
      gqa_pkg::OP_CSET: begin
        c_r[cmd.comp] <= sat32(csum);
      end
      gqa_pkg::OP_QACC: begin
        v_r <= ((cmd.comp == 2'd0) ? 64'd0 : v_r) + {2'b00, p_r[63:2]};
      end
      gqa_pkg::OP_SQINIT: begin
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      gqa_pkg::OP_SQSTEP: begin
        if (v_r >= rb) begin
          v_r   <= v_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      gqa_pkg::OP_DVINIT: begin
        dvd_r <= (DVW'(cabs) << (QUAT_FRAC_BITS - 1)) + DVW'(rr[31:1]);
        rem_r <= '0;
      end
      gqa_pkg::OP_DVSTEP: begin
        rem_r <= dge ? 32'(dtry - {1'b0, rr}) : dtry[31:0];
        dvd_r <= {dvd_r[DVW-2:0], dge};
      end
      gqa_pkg::OP_YACC: begin
        case (cmd.comp)
          2'd1:    sn_r  <= ysh[YW-1:0];
          2'd3:    cs_r  <= ycsh[YW-1:0];
          default: acc_r <= p_r;
        endcase
      end
      gqa_pkg::OP_YPRE: begin
        yzero_r <= (sn_r == '0) && (cs_r == '0);
        if (cs_r < 0) begin
          ang_r <= (sn_r >= 0) ? gqa_pkg::ANG_HALF_TURN : -gqa_pkg::ANG_HALF_TURN;
          cs_r  <= -cs_r;
          sn_r  <= -sn_r;
        end else begin
          ang_r <= '0;
        end
      end
      gqa_pkg::OP_CSTEP: begin
        if (sn_r > 0) begin
          cs_r  <= cs_r + shs;
          sn_r  <= sn_r - shc;
          ang_r <= ang_r + atn;
        end else begin
          cs_r  <= cs_r - shs;
          sn_r  <= sn_r + shc;
          ang_r <= ang_r - atn;
        end
      end
      gqa_pkg::OP_OUT: begin
        qw_r <= att_r[0];
        qx_r <= att_r[1];
        qy_r <= att_r[2];
        qz_r <= att_r[3];
        if (yzero_r) begin
          yaw_r <= '0;
        end else if (yr > 32'sd18000) begin
          yaw_r <= 16'sd18000;
        end else if (yr < -32'sd18000) begin
          yaw_r <= -16'sd18000;
        end else begin
          yaw_r <= yr[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign quat_w       = qw_r;
  assign quat_x       = qx_r;
  assign quat_y       = qy_r;
  assign quat_z       = qz_r;
  assign yaw_centideg = yaw_r;

endmodule

// File: rtl/gyro_quaternion_attitude.sv
// Gyro-driven attitude quaternion integrator.
// in_bus: one raw three-axis gyro sample per item (valid/ready).
// out_bus: one result per input item: quaternion w,x,y,z (Q2.30 at the
//   default QUAT_FRAC_BITS) and yaw in centidegrees.
// cfg_bus: register writes (bias x/y/z, rate scale, deadband, step time),
//   always ready; write only while no item is in flight.
// When the norm is tiny and the quaternion snaps to identity, the divider
//   is skipped. The block takes a new item only once the last one has been
//   written to the output register. Most of the time goes to the
//   bit-serial divider (QUAT_FRAC_BITS + 31 steps per component, four
//   components), then the 32-step square root and the CORDIC loop;
//   products share one multiplier.
// A new item is taken while an earlier result still waits in the output
//   register; if that result is still untaken when the next finishes, the
//   block holds until out ready.
// Synchronous reset loads the identity attitude and default register values
//   and empties the output register.
module gyro_quaternion_attitude #(
  parameter int QUAT_FRAC_BITS = 30,
  parameter int CORDIC_STEPS   = 24
) (
  input logic       clk,
  input logic       rst_n,
  gqa_in_if.sink    in_bus,
  gqa_out_if.source out_bus,
  gqa_cfg_if.sink   cfg_bus
);

  gqa_pkg::cmd_t  cmd;
  gqa_pkg::stat_t stat;

  gqa_ctrl #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gqa_datapath #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .rate_x_raw   (in_bus.rate_x_raw),
    .rate_y_raw   (in_bus.rate_y_raw),
    .rate_z_raw   (in_bus.rate_z_raw),
    .cfg_we       (cfg_bus.valid),
    .cfg_index    (cfg_bus.index),
    .cfg_data     (cfg_bus.data),
    .quat_w       (out_bus.quat_w),
    .quat_x       (out_bus.quat_x),
    .quat_y       (out_bus.quat_y),
    .quat_z       (out_bus.quat_z),
    .yaw_centideg (out_bus.yaw_centideg)
  );

  assign cfg_bus.ready = 1'b1;

endmodule

// File: tb/gqa_attitude_checker.sv
`timescale 1ns / 100ps

module gqa_attitude_checker (
  input  logic clk,
  input  logic rst_n,
  gqa_in_if    in_bus,
  gqa_out_if   out_bus,
  gqa_cfg_if   cfg_bus,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  localparam int FRAC = 30;
  localparam int CSTEPS = 24;

  typedef struct {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] yaw;
  } attitude_t;

  attitude_t expected_q[$];

  longint att[4];
  longint bias_x, bias_y, bias_z;
  longint scale, deadband, step_t;

  longint atan_lut[30] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1
  };

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic longint axis_rate(logic signed [15:0] raw, longint bias);
    longint r, a;
    r = sat32((longint'(raw) - bias) * scale);
    a = (r < 0) ? -r : r;
    return (a < deadband) ? 0 : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint yaw_centideg(longint w, longint x, longint y, longint z);
    longint sn, cs, ang, t;
    sn = (2 * (w * z + x * y)) >>> FRAC;
    cs = ((longint'(1) <<< (2 * FRAC)) - 2 * (y * y + z * z)) >>> FRAC;
    ang = 0;
    if (sn == 0 && cs == 0) return 0;
    // left half-plane: turn by half a turn first
    if (cs < 0) begin
      ang = (sn >= 0) ? longint'(gqa_pkg::ANG_HALF_TURN) : -longint'(gqa_pkg::ANG_HALF_TURN);
      cs = -cs;
      sn = -sn;
    end
    for (int i = 0; i < CSTEPS && i < 30; i++) begin
      if (sn > 0) begin
        t = cs + (sn >>> i);
        sn = sn - (cs >>> i);
        ang = ang + atan_lut[i];
      end else begin
        t = cs - (sn >>> i);
        sn = sn + (cs >>> i);
        ang = ang - atan_lut[i];
      end
      cs = t;
    end
    ang = (ang + 32768) >>> 16;
    if (ang > 18000) ang = 18000;
    if (ang < -18000) ang = -18000;
    return ang;
  endfunction

  task automatic integrate_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                                  logic signed [15:0] rz);
    longint gx, gy, gz, w, x, y, z, s;
    longint d[4], c[4];
    longint unsigned ssq, r, a, q;
    attitude_t e;
    gx = axis_rate(rx, bias_x);
    gy = axis_rate(ry, bias_y);
    gz = axis_rate(rz, bias_z);
    w = att[0]; x = att[1]; y = att[2]; z = att[3];
    d[0] = -x * gx - y * gy - z * gz;
    d[1] = w * gx + y * gz - z * gy;
    d[2] = w * gy - x * gz + z * gx;
    d[3] = w * gz + x * gy - y * gx;
    c[0] = w; c[1] = x; c[2] = y; c[3] = z;
    ssq = 0;
    for (int i = 0; i < 4; i++) begin
      s = round_shift(d[i], 24);
      c[i] = sat32(c[i] + round_shift(s * step_t, 25));
      ssq = ssq + (longint'(c[i] * c[i]) >> 2);
    end
    r = int_sqrt(ssq);
    if (r * 10000 < (64'd1 << (FRAC - 1))) begin
      // norm collapsed: snap back to identity
      att[0] = longint'(1) <<< FRAC;
      att[1] = 0; att[2] = 0; att[3] = 0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        a = (c[i] < 0) ? -c[i] : c[i];
        q = ((a << (FRAC - 1)) + (r >> 1)) / r;
        att[i] = sat32((c[i] < 0) ? -longint'(q) : longint'(q));
      end
    end
    e.w = att[0][31:0];
    e.x = att[1][31:0];
    e.y = att[2][31:0];
    e.z = att[3][31:0];
    e.yaw = 16'(yaw_centideg(att[0], att[1], att[2], att[3]));
    expected_q.push_back(e);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      att[0] = longint'(1) <<< FRAC;
      att[1] = 0; att[2] = 0; att[3] = 0;
      bias_x = 0; bias_y = 0; bias_z = 0;
      scale = 17852; deadband = 2516582; step_t = 83886;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          gqa_pkg::REG_BIAS_X:   bias_x = longint'($signed(cfg_bus.data[15:0]));
          gqa_pkg::REG_BIAS_Y:   bias_y = longint'($signed(cfg_bus.data[15:0]));
          gqa_pkg::REG_BIAS_Z:   bias_z = longint'($signed(cfg_bus.data[15:0]));
          gqa_pkg::REG_SCALE:    scale = cfg_bus.data[15:0];
          gqa_pkg::REG_DEADBAND: deadband = cfg_bus.data;
          gqa_pkg::REG_STEP:     step_t = cfg_bus.data;
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none actual w=%0d", $time,
                   out_bus.quat_w);
          fail_count++;
        end else begin
          attitude_t e;
          e = expected_q.pop_front();
          check_field("quat_w", e.w, out_bus.quat_w);
          check_field("quat_x", e.x, out_bus.quat_x);
          check_field("quat_y", e.y, out_bus.quat_y);
          check_field("quat_z", e.z, out_bus.quat_z);
          check_field("yaw_centideg", e.yaw, out_bus.yaw_centideg);
        end
      end
      if (in_bus.valid && in_bus.ready)
        integrate_sample(in_bus.rate_x_raw, in_bus.rate_y_raw, in_bus.rate_z_raw);
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/tb_gyro_quaternion_attitude.sv
`timescale 1ns / 100ps

module tb_gyro_quaternion_attitude;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 138;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, results_seen;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   rx_cycle = 0;

  gqa_in_if  in_bus();
  gqa_out_if out_bus();
  gqa_cfg_if cfg_bus();

  gyro_quaternion_attitude u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  gqa_attitude_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.rate_x_raw = '0;
    in_bus.rate_y_raw = '0;
    in_bus.rate_z_raw = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = gqa_pkg::REG_BIAS_X;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
  end

  // receiver: random stalls, a calm window, and one long hold-off
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 50000 && rx_cycle < 53000)
      out_bus.ready <= 1'b0;
    else if (rx_cycle >= 120000 && rx_cycle < 180000)
      out_bus.ready <= 1'b1;
    else
      out_bus.ready <= ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("gyro_quaternion_attitude: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [23:0] value);
    cfg_bus.index = idx;
    cfg_bus.data = value;
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_config(logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                            logic [15:0] sc, logic [23:0] db, logic [23:0] st);
    cfg_write(gqa_pkg::REG_BIAS_X, {8'h00, bx});
    cfg_write(gqa_pkg::REG_BIAS_Y, {8'h00, by});
    cfg_write(gqa_pkg::REG_BIAS_Z, {8'h00, bz});
    cfg_write(gqa_pkg::REG_SCALE, {8'h00, sc});
    cfg_write(gqa_pkg::REG_DEADBAND, db);
    cfg_write(gqa_pkg::REG_STEP, st);
    // unused indexes must be ignored
    cfg_write(3'd6, 24'hFFFFFF);
    cfg_write(3'd7, 24'h123456);
  endtask

  // one item; valid stays high into the next item unless a gap is drawn
  task automatic send_sample(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz, bit calm);
    if (!calm && $urandom_range(99) < 31) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_bus.rate_x_raw = rx;
    in_bus.rate_y_raw = ry;
    in_bus.rate_z_raw = rz;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_rate(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(600)) - 300);
      default: return 16'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  initial begin
    int mode;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: default registers, field extremes and bit patterns
    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    send_sample(16'h0001, 16'hFFFF, 16'h0000, 1'b0);
    // spin about z one way, then part of the way back
    repeat (8) send_sample(16'h0000, 16'h0000, 16'h7FFF, 1'b0);
    repeat (4) send_sample(16'h0000, 16'h0000, 16'h8000, 1'b0);
    drain();

    // harshest scaling: rate saturation, no deadband, huge step
    set_config(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 24'h000000, 24'hFFFFFF);
    send_sample(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h1234, 16'hEDCB, 16'h7FFF, 1'b0);
    // deadband wide open swallows everything
    drain();
    set_config(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 24'hFFFFFF, 24'h000000);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(16'h0000, 16'h0000, 16'h0000, 16'd17852, 24'd2516582, 24'd83886);
        1: set_config(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 24'h000000, 24'hFFFFFF);
        2: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0001, 24'h000000, 24'h000001);
        3: set_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'd17852, 24'hFFFFFF, 24'd83886);
        default: set_config(16'($urandom_range(400)) - 16'd200, 16'($urandom),
                            16'($urandom_range(400)) - 16'd200, 16'($urandom),
                            24'($urandom_range(4000000)), 24'($urandom));
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        mode = $urandom_range(2);
        send_sample(rand_rate(mode), rand_rate(mode), rand_rate(mode),
                    (p == 5) || (i >= 40 && i < 80));
      end
      // sender pauses until every result is back
      drain();
    end

    $display("sent %0d gyro samples over %0d register settings, %0d attitude results",
             items_sent, PHASES + 3, results_seen);
    $display("covered field extremes, rate saturation, deadband limits and yaw wrap");
    if (fail_count == 0)
      $display("gyro_quaternion_attitude: match");
    else
      $display("gyro_quaternion_attitude: mismatch");
    $finish;
  end

endmodule
